// File: rtl/core/npc_pkg.sv
// Package: palette table, distance helpers and pipeline types for nearest palette search.
package npc_pkg;

  localparam int unsigned NumEntries = 256;
  localparam int unsigned DistW      = 18;
  localparam int unsigned IdxW       = 8;

  typedef logic [23:0]      rgb_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef struct packed {
    dist_t cost;
    idx_t  idx;
  } cand_t;

  localparam rgb_t PALETTE [NumEntries] = '{
    24'h000000, 24'h0f0f0f, 24'h1f1f1f, 24'h2f2f2f, 24'h3f3f3f, 24'h4b4b4b, 24'h5b5b5b, 24'h6b6b6b,
    24'h7b7b7b, 24'h8b8b8b, 24'h9b9b9b, 24'habab_ab, 24'hbbbbbb, 24'hcbcbcb, 24'hdbdbdb, 24'hebebeb,
    24'h634b23, 24'h5b431f, 24'h533f1f, 24'h4f3b1b, 24'h47371b, 24'h3f2f17, 24'h3b2b17, 24'h332713,
    24'h2f2313, 24'h2b1f13, 24'h271b0f, 24'h23170f, 24'h1b130b, 24'h170f0b, 24'h130f07, 24'h0f0b07,
    24'h5f5f6f, 24'h5b5b67, 24'h5b535f, 24'h574f5b, 24'h534b53, 24'h4f474b, 24'h473f43, 24'h3f3b3b,
    24'h3b3737, 24'h332f2f, 24'h2f2b2b, 24'h272727, 24'h232323, 24'h1b1b1b, 24'h171717, 24'h131313,
    24'h8f7753, 24'h7b6343, 24'h735b3b, 24'h674f2f, 24'hcf974b, 24'ha77b3b, 24'h8b672f, 24'h6f5327,
    24'heb9f27, 24'hcb8b23, 24'haf771f, 24'h93631b, 24'h774f17, 24'h5b3b0f, 24'h3f270b, 24'h231707,
    24'ha73b2b, 24'h9f2f23, 24'h972b1b, 24'h8b2713, 24'h7f1f0f, 24'h73170b, 24'h671707, 24'h571300,
    24'h4b0f00, 24'h430f00, 24'h3b0f00, 24'h330b00, 24'h2b0b00, 24'h230b00, 24'h1b0700, 24'h130700,
    24'h7b5f4b, 24'h735743, 24'h6b533f, 24'h674f3b, 24'h5f4737, 24'h574333, 24'h533f2f, 24'h4b372b,
    24'h433327, 24'h3f2f23, 24'h37271b, 24'h2f2317, 24'h271b13, 24'h1f170f, 24'h170f0b, 24'h0f0b07,
    24'h6f3b17, 24'h5f3717, 24'h532f17, 24'h432b17, 24'h372313, 24'h271b0f, 24'h1b130b, 24'h0f0b07,
    24'hb35b4f, 24'hbf7b6f, 24'hcb9b93, 24'hd7bbb7, 24'hcbd7df, 24'hb3c7d3, 24'h9fb7c3, 24'h87a7b7,
    24'h7397a7, 24'h5b879b, 24'h47778b, 24'h2f677f, 24'h17536f, 24'h134b67, 24'h0f435b, 24'h0b3f53,
    24'h07374b, 24'h072f3f, 24'h072733, 24'h001f2b, 24'h00171f, 24'h000f13, 24'h00070b, 24'h000000,
    24'h8b5757, 24'h834f4f, 24'h7b4747, 24'h734343, 24'h6b3b3b, 24'h633333, 24'h5b2f2f, 24'h572b2b,
    24'h4b2323, 24'h3f1f1f, 24'h331b1b, 24'h2b1313, 24'h1f0f0f, 24'h130b0b, 24'h0b0707, 24'h000000,
    24'h979f7b, 24'h8f9773, 24'h878b6b, 24'h7f8363, 24'h777b5f, 24'h737357, 24'h6b6b4f, 24'h636347,
    24'h5b5b43, 24'h4f4f3b, 24'h434333, 24'h37372b, 24'h2f2f23, 24'h23231b, 24'h171713, 24'h0f0f0b,
    24'h9f4b3f, 24'h934337, 24'h8b3b2f, 24'h7f3727, 24'h772f23, 24'h6b2b1b, 24'h632317, 24'h571f13,
    24'h4f1b0f, 24'h43170b, 24'h37130b, 24'h2b0f07, 24'h1f0b07, 24'h170700, 24'h0b0000, 24'h000000,
    24'h777bcf, 24'h6f73c3, 24'h676bb7, 24'h6363a7, 24'h5b5b9b, 24'h53578f, 24'h4b4f7f, 24'h474773,
    24'h3f3f67, 24'h373757, 24'h2f2f4b, 24'h27273f, 24'h231f2f, 24'h1b1723, 24'h130f17, 24'h0b0707,
    24'h9bab7b, 24'h8f9f6f, 24'h879763, 24'h7b8b57, 24'h73834b, 24'h677743, 24'h5f6f3b, 24'h576733,
    24'h4b5b27, 24'h3f4f1b, 24'h374313, 24'h2f3b0b, 24'h232f07, 24'h1b2300, 24'h131700, 24'h0b0f00,
    24'h00ff00, 24'h23e70f, 24'h3fd31b, 24'h53bb27, 24'h5fa72f, 24'h5f8f33, 24'h5f7b33, 24'hffffff,
    24'hffffd3, 24'hffffa7, 24'hffff7f, 24'hffff53, 24'hffff27, 24'hffeb1f, 24'hffd717, 24'hffbf0f,
    24'hffab07, 24'hff9300, 24'hef7f00, 24'he36b00, 24'hd35700, 24'hc74700, 24'hb73b00, 24'hab2b00,
    24'h9b1f00, 24'h8f1700, 24'h7f0f00, 24'h730700, 24'h5f0000, 24'h470000, 24'h2f0000, 24'h1b0000,
    24'hef0000, 24'h3737ff, 24'hff0000, 24'h0000ff, 24'h2b2b23, 24'h1b1b17, 24'h13130f, 24'heb977f,
    24'hc37353, 24'h9f5733, 24'h7b3f1b, 24'hebd3c7, 24'hc7ab9b, 24'ha78b77, 24'h876b57, 24'h9f5b53
  };

  function automatic logic [15:0] chan_sq(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return {8'h00, d} * {8'h00, d};
  endfunction

  function automatic dist_t rgb_dist(input rgb_t p, input rgb_t q);
    return dist_t'(chan_sq(p[23:16], q[23:16])) + dist_t'(chan_sq(p[15:8], q[15:8]))
         + dist_t'(chan_sq(p[7:0], q[7:0]));
  endfunction

  // Strictly smaller wins; a is the lower index group.
  function automatic cand_t cand_min(input cand_t a, input cand_t b);
    return (b.cost < a.cost) ? b : a;
  endfunction

endpackage

// File: rtl/core/npc_if.sv
// Interfaces: pixel request channel and palette index result channel.
interface npc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface npc_idx_if;
  logic       valid;
  logic       ready;
  logic [7:0] palette_index;
  modport source (output valid, palette_index, input ready);
  modport sink   (input valid, palette_index, output ready);
endinterface

// File: rtl/core/nearest_palette_color.sv
// Top level: nearest palette entry search as a pipelined distance and min tree.
// Throughput one request per cycle while idx_o.ready does not stall the result.
// Stages: input register, distances, then three registered min-tree levels (256->32->4->1).
// A stall holds full stages; a stage advances whenever it is empty or its successor moves.
// Reset (rst_ni low, async) clears all valid bits; payload registers are not reset.
module nearest_palette_color
  import npc_pkg::*;
#(
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  npc_pix_if.sink    pix_i,
  npc_idx_if.source  idx_o
);

  localparam int unsigned NumStg = 5;
  localparam int unsigned L1 = 32;
  localparam int unsigned L2 = 4;

  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] adv;

  always_comb begin
    adv[NumStg-1] = !vld_q[NumStg-1] || idx_o.ready;
    for (int s = NumStg - 2; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  assign pix_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= pix_i.valid;
      for (int s = 1; s < NumStg; s++) begin
        if (adv[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  rgb_t  pix_q;
  dist_t dist_q [NumEntries];
  cand_t l1_q [L1];
  cand_t l2_q [L2];
  cand_t fin_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) pix_q <= {pix_i.red, pix_i.green, pix_i.blue};
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < NumEntries; i++) begin
        dist_q[i] <= (i < PALETTE_SIZE) ? rgb_dist(pix_q, PALETTE[i]) : '1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_t m;
    if (adv[2]) begin
      for (int g = 0; g < L1; g++) begin
        m = '{cost: dist_q[g*8], idx: idx_t'(g*8)};
        for (int k = 1; k < 8; k++) begin
          m = cand_min(m, '{cost: dist_q[g*8+k], idx: idx_t'(g*8+k)});
        end
        l1_q[g] <= m;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_t m;
    if (adv[3]) begin
      for (int g = 0; g < L2; g++) begin
        m = l1_q[g*8];
        for (int k = 1; k < 8; k++) m = cand_min(m, l1_q[g*8+k]);
        l2_q[g] <= m;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_t m;
    if (adv[4]) begin
      m = l2_q[0];
      for (int k = 1; k < L2; k++) m = cand_min(m, l2_q[k]);
      fin_q <= m;
    end
  end

  assign idx_o.valid         = vld_q[NumStg-1];
  assign idx_o.palette_index = fin_q.idx;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_o.valid && !idx_o.ready |=> idx_o.valid && $stable(idx_o.palette_index))
    else $error("result changed under stall");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && !adv[4] |=> vld_q[3])
    else $error("stalled stage lost its request");
  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_o.valid |-> 32'(idx_o.palette_index) < PALETTE_SIZE)
    else $error("index beyond palette size");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> pix_i.ready)
    else $error("empty input stage not ready");

endmodule
